[hdl/ocrwsn_pkg.sv]
package ocrwsn_pkg;

  // Code unit and run store geometry
  localparam int UNIT_W      = 16;
  localparam int RUN_DEPTH   = 16;
  localparam int RUN_CNT_W   = $clog2(RUN_DEPTH + 1);
  localparam int RUN_ADDR_W  = $clog2(RUN_DEPTH);
  localparam logic [RUN_CNT_W-1:0] RUN_FULL = RUN_CNT_W'(RUN_DEPTH);

  // Code points with a role of their own
  localparam logic [UNIT_W-1:0] CH_TAB  = 16'h0009;
  localparam logic [UNIT_W-1:0] CH_LF   = 16'h000A;
  localparam logic [UNIT_W-1:0] CH_VT   = 16'h000B;
  localparam logic [UNIT_W-1:0] CH_FF   = 16'h000C;
  localparam logic [UNIT_W-1:0] CH_CR   = 16'h000D;
  localparam logic [UNIT_W-1:0] CH_SP   = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_NEL  = 16'h0085;
  localparam logic [UNIT_W-1:0] CH_NBSP = 16'h00A0;
  localparam logic [UNIT_W-1:0] CH_LSEP = 16'h2028;
  localparam logic [UNIT_W-1:0] CH_PSEP = 16'h2029;
  localparam logic [UNIT_W-1:0] CH_IDSP = 16'h3000;
  localparam logic [UNIT_W-1:0] CH_BOM  = 16'hFEFF;

  // Work to be done for one accepted word, in this order:
  // push a space, flush the run, emit LF, then push or emit the unit
  typedef struct packed {
    logic              push_sp;
    logic              flush;
    logic              flush_en;
    logic              lf;
    logic              c_push;
    logic              c_emit;
    logic [UNIT_W-1:0] unit;
  } ocrwsn_plan_t;

  // Commands to the run buffer
  typedef struct packed {
    logic                  push;
    logic [UNIT_W-1:0]     unit;
    logic                  clear;
    logic                  rd_en;
    logic [RUN_ADDR_W-1:0] rd_addr;
  } ocrwsn_buf_cmd_t;

endpackage

[hdl/ocrwsn_if.sv]
interface ocrwsn_in_if;
  import ocrwsn_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [UNIT_W-1:0] code_unit;

  modport source (output valid, output mode, output code_unit, input ready);
  modport sink (input valid, input mode, input code_unit, output ready);
endinterface

interface ocrwsn_out_if;
  import ocrwsn_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] out_unit;
  logic              last_of_run;
  logic              run_truncated;

  modport source (output valid, output out_unit, output last_of_run,
                  output run_truncated, input ready);
  modport sink (input valid, input out_unit, input last_of_run,
                input run_truncated, output ready);
endinterface

[hdl/ocrwsn_plan.sv]
module ocrwsn_plan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         mode,
  input  logic [ocrwsn_pkg::UNIT_W-1:0] code_unit,
  output ocrwsn_pkg::ocrwsn_plan_t     plan
);
  import ocrwsn_pkg::*;

  logic swallow_lf_r, swallow_lf_nxt;
  logic line_has_content_r, line_has_content_nxt;
  logic pending_space_r, pending_space_nxt;
  logic paragraph_pending_r, paragraph_pending_nxt;
  logic text_started_r, text_started_nxt;
  logic last_ascii_word_r, last_ascii_word_nxt;
  logic prev_jp_r, prev_jp_nxt;
  logic sep_lf, sep_sp, c_ws, c_jp, c_aw;

  function automatic logic is_break(input logic [UNIT_W-1:0] c);
    return c == CH_CR || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_NEL || c == CH_LSEP || c == CH_PSEP;
  endfunction

  function automatic logic is_inline_ws(input logic [UNIT_W-1:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_NBSP || c == 16'h1680 ||
           (c >= 16'h2000 && c <= 16'h200A) || c == 16'h202F ||
           c == 16'h205F || c == CH_IDSP || c == CH_BOM;
  endfunction

  function automatic logic is_japanese(input logic [UNIT_W-1:0] c);
    return (c >= 16'h3040 && c <= 16'h30FF) || (c >= 16'h31F0 && c <= 16'h31FF) ||
           (c >= 16'h3400 && c <= 16'h4DBF) || (c >= 16'h4E00 && c <= 16'h9FFF) ||
           (c >= 16'hF900 && c <= 16'hFAFF) || (c >= 16'hFF66 && c <= 16'hFF9D) ||
           (c >= 16'h3005 && c <= 16'h3007);
  endfunction

  function automatic logic is_ascii_word(input logic [UNIT_W-1:0] c);
    return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
           (c >= 16'h0030 && c <= 16'h0039);
  endfunction

  assign c_ws = is_inline_ws(code_unit);
  assign c_jp = is_japanese(code_unit);
  assign c_aw = is_ascii_word(code_unit);

  // Decide the line state update and the work for this word
  always_comb begin
    swallow_lf_nxt        = swallow_lf_r;
    line_has_content_nxt  = line_has_content_r;
    pending_space_nxt     = pending_space_r;
    paragraph_pending_nxt = paragraph_pending_r;
    text_started_nxt      = text_started_r;
    last_ascii_word_nxt   = last_ascii_word_r;
    prev_jp_nxt           = prev_jp_r;
    sep_lf                = 1'b0;
    sep_sp                = 1'b0;
    plan                  = '0;
    plan.unit             = code_unit;
    if (mode) begin
      // end of text: flush the held run, then return to the start state
      plan.flush            = 1'b1;
      plan.flush_en         = !prev_jp_r;
      swallow_lf_nxt        = 1'b0;
      line_has_content_nxt  = 1'b0;
      pending_space_nxt     = 1'b0;
      paragraph_pending_nxt = 1'b0;
      text_started_nxt      = 1'b0;
      last_ascii_word_nxt   = 1'b0;
      prev_jp_nxt           = 1'b0;
    end else if (swallow_lf_r && code_unit == CH_LF) begin
      swallow_lf_nxt = 1'b0;
    end else begin
      swallow_lf_nxt = (code_unit == CH_CR);
      if (is_break(code_unit)) begin
        if (!line_has_content_r && text_started_r) begin
          paragraph_pending_nxt = 1'b1;
        end
        line_has_content_nxt = 1'b0;
        pending_space_nxt    = 1'b0;
      end else if (code_unit == CH_SP || code_unit == CH_TAB) begin
        if (line_has_content_r) begin
          pending_space_nxt = 1'b1;
        end
      end else begin
        // content: pick the joiner, then place the unit itself
        if (!line_has_content_r) begin
          if (text_started_r) begin
            if (paragraph_pending_r) begin
              sep_lf = 1'b1;
            end else if (last_ascii_word_r && c_aw) begin
              sep_sp = 1'b1;
            end
          end
          paragraph_pending_nxt = 1'b0;
          line_has_content_nxt  = 1'b1;
          text_started_nxt      = 1'b1;
        end else if (pending_space_r) begin
          sep_sp = 1'b1;
        end
        pending_space_nxt   = 1'b0;
        last_ascii_word_nxt = c_aw;
        plan.push_sp        = sep_sp;
        plan.lf             = sep_lf;
        if (sep_lf) begin
          plan.flush    = 1'b1;
          plan.flush_en = !prev_jp_r;
          prev_jp_nxt   = 1'b0;
        end
        if (c_ws) begin
          plan.c_push = 1'b1;
        end else begin
          plan.c_emit = 1'b1;
          prev_jp_nxt = c_jp;
          if (!sep_lf) begin
            plan.flush    = 1'b1;
            plan.flush_en = !prev_jp_r && !c_jp;
          end
        end
      end
    end
  end

  // Hold line state, advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swallow_lf_r        <= 1'b0;
      line_has_content_r  <= 1'b0;
      pending_space_r     <= 1'b0;
      paragraph_pending_r <= 1'b0;
      text_started_r      <= 1'b0;
      last_ascii_word_r   <= 1'b0;
      prev_jp_r           <= 1'b0;
    end else if (take) begin
      swallow_lf_r        <= swallow_lf_nxt;
      line_has_content_r  <= line_has_content_nxt;
      pending_space_r     <= pending_space_nxt;
      paragraph_pending_r <= paragraph_pending_nxt;
      text_started_r      <= text_started_nxt;
      last_ascii_word_r   <= last_ascii_word_nxt;
      prev_jp_r           <= prev_jp_nxt;
    end
  end

endmodule

[hdl/ocrwsn_run_buf.sv]
module ocrwsn_run_buf (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ocrwsn_pkg::ocrwsn_buf_cmd_t     cmd,
  output logic [ocrwsn_pkg::UNIT_W-1:0]    rd_data,
  output logic [ocrwsn_pkg::RUN_CNT_W-1:0] count,
  output logic                            overflow
);
  import ocrwsn_pkg::*;

  logic [UNIT_W-1:0]    mem [RUN_DEPTH];
  logic [UNIT_W-1:0]    rd_data_r;
  logic [RUN_CNT_W-1:0] count_r;
  logic                 overflow_r;
  logic                 room;

  assign room     = count_r < RUN_FULL;
  assign rd_data  = rd_data_r;
  assign count    = count_r;
  assign overflow = overflow_r;

  // Write at the fill point; reads are registered into rd_data
  always_ff @(posedge clk) begin
    if (cmd.push && room) begin
      mem[count_r[RUN_ADDR_W-1:0]] <= cmd.unit;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Track fill count and overflow of the current run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (cmd.clear) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (cmd.push) begin
      if (room) begin
        count_r <= count_r + 1'b1;
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

endmodule

[hdl/ocr_text_whitespace_normalizer_core.sv]
// Whitespace normaliser for OCR text, one UTF-16 code unit per word.
// in_ch (sink): mode = 0 carries a text code unit in code_unit, mode = 1
//   marks end of text and flushes the held whitespace run.
// out_ch (source): normalised code units; last_of_run marks the final word
//   caused by one input word, run_truncated marks units of a flushed run
//   that held more than RUN_DEPTH units (the excess is dropped).
// Inline whitespace other than SP and TAB, and joiner spaces, is held in a
// RUN_DEPTH-entry synchronous RAM until the next visible unit or end of
// text decides whether the run is kept or dropped. A fast-path word is in
// the output register in the cycle after it is accepted; one word per cycle
// is taken when nothing held is flushed, no joiner or LF is queued and
// out_ch is free. Else the sequencer pushes the space, then reads the run
// through the single RAM read port, one unit a cycle while out_ch is free.
// Reset clears all line state and the run count; no clearing pass is needed.
// When out_ch stalls, the output register holds its word; input is still
// taken while only plain state updates or RAM pushes are needed, and the
// sequencer waits whenever it has a word to place.
module ocr_text_whitespace_normalizer_core (
  input  logic               clk,
  input  logic               rst_n,
  ocrwsn_in_if.sink          in_ch,
  ocrwsn_out_if.source       out_ch
);
  import ocrwsn_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PUSH_SP, S_FLUSH, S_LF, S_FINAL} state_t;

  state_t               state_r, state_nxt;
  ocrwsn_plan_t         pl_r, pl_nxt;
  ocrwsn_plan_t         plan;
  ocrwsn_buf_cmd_t      cmd;
  logic [RUN_CNT_W-1:0] idx_r, idx_nxt, idx_inc;
  logic                 rdv_r, rdv_nxt;
  logic                 out_valid_r;
  logic [UNIT_W-1:0]    out_unit_r;
  logic                 out_last_r, out_trunc_r;
  logic [UNIT_W-1:0]    rd_data;
  logic [RUN_CNT_W-1:0] run_cnt;
  logic                 run_ovf;
  logic                 take, slot_free, fast, flush_done;
  logic                 ld, ld_last, ld_trunc;
  logic [UNIT_W-1:0]    ld_unit;

  function automatic state_t after_flush(input ocrwsn_plan_t p);
    if (p.lf) return S_LF;
    if (p.c_push || p.c_emit) return S_FINAL;
    return S_IDLE;
  endfunction

  function automatic state_t after_push(input ocrwsn_plan_t p);
    return p.flush ? S_FLUSH : after_flush(p);
  endfunction

  function automatic state_t first_step(input ocrwsn_plan_t p);
    return p.push_sp ? S_PUSH_SP : after_push(p);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign take        = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign idx_inc     = idx_r + 1'b1;
  assign flush_done  = (idx_inc == run_cnt);

  ocrwsn_plan u_plan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .mode      (in_ch.mode),
    .code_unit (in_ch.code_unit),
    .plan      (plan)
  );

  ocrwsn_run_buf u_run_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_data  (rd_data),
    .count    (run_cnt),
    .overflow (run_ovf)
  );

  // Sequence the steps of one word against the run RAM and output register
  always_comb begin
    cmd       = '0;
    ld        = 1'b0;
    ld_unit   = pl_r.unit;
    ld_last   = 1'b1;
    ld_trunc  = 1'b0;
    fast      = 1'b0;
    state_nxt = state_r;
    pl_nxt    = pl_r;
    idx_nxt   = idx_r;
    rdv_nxt   = rdv_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          fast = !plan.push_sp && !plan.lf &&
                 !(plan.flush && plan.flush_en && run_cnt != '0) &&
                 !(plan.c_emit && !slot_free);
          if (fast) begin
            cmd.clear = plan.flush;
            cmd.push  = plan.c_push;
            cmd.unit  = plan.unit;
            ld        = plan.c_emit;
            ld_unit   = plan.unit;
          end else begin
            pl_nxt    = plan;
            state_nxt = first_step(plan);
          end
        end
      end
      S_PUSH_SP: begin
        cmd.push  = 1'b1;
        cmd.unit  = CH_SP;
        state_nxt = after_push(pl_r);
      end
      S_FLUSH: begin
        if (!pl_r.flush_en || run_cnt == '0) begin
          // drop the run
          cmd.clear = 1'b1;
          state_nxt = after_flush(pl_r);
        end else if (!rdv_r) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r[RUN_ADDR_W-1:0];
          rdv_nxt     = 1'b1;
        end else if (slot_free) begin
          ld       = 1'b1;
          ld_unit  = rd_data;
          ld_trunc = run_ovf;
          ld_last  = flush_done && !pl_r.lf && !pl_r.c_emit;
          if (flush_done) begin
            cmd.clear = 1'b1;
            rdv_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = after_flush(pl_r);
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_inc[RUN_ADDR_W-1:0];
            idx_nxt     = idx_inc;
          end
        end
      end
      S_LF: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_unit   = CH_LF;
          ld_last   = !pl_r.c_emit;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (pl_r.c_push) begin
          cmd.push  = 1'b1;
          cmd.unit  = pl_r.unit;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold sequencer state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pl_r    <= pl_nxt;
      idx_r   <= idx_nxt;
      rdv_r   <= rdv_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
        out_unit_r  <= ld_unit;
        out_last_r  <= ld_last;
        out_trunc_r <= ld_trunc;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_unit      = out_unit_r;
  assign out_ch.last_of_run   = out_last_r;
  assign out_ch.run_truncated = out_trunc_r;

endmodule

[hdl/ocrwsn_checker.sv]
module ocrwsn_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ocrwsn_pkg::UNIT_W-1:0] out_unit,
  input logic                         out_last,
  input logic                         out_trunc
);
  import ocrwsn_pkg::*;

  // A stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn while stalled");

  // A stalled word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_unit) && $stable(out_last) &&
                                $stable(out_trunc))
    else $error("output word changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Only buffered whitespace may carry the truncation flag; LF and CR are checked
  a_trunc_ws: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trunc |-> out_unit != CH_LF && out_unit != CH_CR)
    else $error("line break flagged as truncated run");

endmodule

bind ocr_text_whitespace_normalizer_core ocrwsn_checker u_ocrwsn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_unit  (out_ch.out_unit),
  .out_last  (out_ch.last_of_run),
  .out_trunc (out_ch.run_truncated)
);
